>>> sv/page_frame_allocator_refcount_macros.svh
// Assertion macros for the page frame allocator, used by the command sequencer pfa_ctrl.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PAGE_FRAME_ALLOCATOR_REFCOUNT_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_REFCOUNT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pfa_pkg.sv
// Package for the page frame allocator: request types, command and status codes,
// sequencer states and default sizes. No dependencies.
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int PAGE_COUNT_DEF  = 4096;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int RESV_W          = 13;
    localparam int PAGE_W          = 12;
    localparam int COUNT_OUT_W     = 16;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_INC   = 2'd1,
        CMD_DEC   = 2'd2,
        CMD_TRY   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_NOMEM = 3'd1,
        ST_REFD  = 3'd2,
        ST_RESV  = 3'd3,
        ST_UNDER = 3'd4,
        ST_OVER  = 3'd5,
        ST_FREE  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_EXEC
    } state_t;

    typedef enum logic [2:0] {
        K_OP,
        K_POP,
        K_FRESH,
        K_NOMEM,
        K_RANGE
    } kind_t;

    typedef struct packed {
        cmd_t               command;
        logic [PAGE_W-1:0]  page_index;
    } in_req_t;

    typedef struct packed {
        logic [PAGE_W-1:0]      result_page;
        status_t                status;
        logic [COUNT_OUT_W-1:0] count_after;
    } out_req_t;

    typedef struct packed {
        logic cnt_re;
        logic cnt_we;
        logic stk_re;
        logic stk_we;
    } mem_en_t;

endpackage

>>> sv/pfa_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/pfa_ctrl.sv
// Command sequencer of the page frame allocator: clearing pass, memory read-modify-write,
// free stack bookkeeping and the result register. Depends on pfa_pkg and the macro header.
`timescale 1ns / 1ps
`include "page_frame_allocator_refcount_macros.svh"

module pfa_ctrl #(
    parameter int PAGE_COUNT  = pfa_pkg::PAGE_COUNT_DEF,
    parameter int COUNT_WIDTH = pfa_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  pfa_pkg::in_req_t               in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output pfa_pkg::out_req_t              out_data,
    input  logic [pfa_pkg::RESV_W-1:0]     reserved_pages,
    output pfa_pkg::mem_en_t               mem_en,
    output logic [$clog2(PAGE_COUNT)-1:0]  cnt_waddr,
    output logic [COUNT_WIDTH:0]           cnt_wdata,
    output logic [$clog2(PAGE_COUNT)-1:0]  cnt_raddr,
    input  logic [COUNT_WIDTH:0]           cnt_rdata,
    output logic [$clog2(PAGE_COUNT)-1:0]  stk_waddr,
    output logic [$clog2(PAGE_COUNT)-1:0]  stk_wdata,
    output logic [$clog2(PAGE_COUNT)-1:0]  stk_raddr,
    input  logic [$clog2(PAGE_COUNT)-1:0]  stk_rdata
);

    localparam int PW = $clog2(PAGE_COUNT);
    localparam int NW = $clog2(PAGE_COUNT + 1);
    localparam int CW = COUNT_WIDTH;
    localparam int LW = (NW > pfa_pkg::RESV_W) ? NW : pfa_pkg::RESV_W;
    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

    pfa_pkg::state_t state_reg, state_next;
    pfa_pkg::kind_t  kind_reg, kind_next;
    pfa_pkg::cmd_t   cmd_reg, cmd_next;
    logic [pfa_pkg::PAGE_W-1:0] idx_reg, idx_next;
    logic [PW-1:0]   page_reg, page_next;
    logic [PW-1:0]   clr_reg, clr_next;
    logic [NW-1:0]   fill_reg, fill_next;
    logic [NW-1:0]   fresh_reg, fresh_next;
    logic            out_valid_reg, out_valid_next;
    pfa_pkg::out_req_t out_data_reg, out_data_next;

    logic [LW-1:0]   resv_ext;
    logic [LW-1:0]   resv_lim;
    logic [LW-1:0]   in_idx_w;
    logic [LW-1:0]   op_idx_w;
    logic            accept;
    logic            commit;
    logic            clear_done;
    logic [CW-1:0]   cur_count;
    logic [CW-1:0]   new_count;
    logic            do_push;
    logic            push_ok;
    logic            cnt_write_op;
    pfa_pkg::out_req_t res;

    assign resv_ext   = LW'(reserved_pages);
    assign resv_lim   = (resv_ext > LW'(PAGE_COUNT)) ? LW'(PAGE_COUNT) : resv_ext;
    assign in_idx_w   = LW'(in_data.page_index);
    assign op_idx_w   = LW'(idx_reg);
    assign accept     = (state_reg == pfa_pkg::S_IDLE) && in_valid;
    assign commit     = (state_reg == pfa_pkg::S_EXEC) && (!out_valid_reg || !out_stall);
    assign clear_done = (clr_reg == PW'(PAGE_COUNT - 1));
    assign cur_count  = cnt_rdata[CW-1:0];
    assign in_stall   = (state_reg != pfa_pkg::S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfa_pkg::S_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = pfa_pkg::S_IDLE;
                end
            end
            pfa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.command == pfa_pkg::CMD_ALLOC && fill_reg != '0)
                    begin
                        state_next = pfa_pkg::S_POP;
                    end
                    else
                    begin
                        state_next = pfa_pkg::S_EXEC;
                    end
                end
            end
            pfa_pkg::S_POP:
            begin
                state_next = pfa_pkg::S_EXEC;
            end
            pfa_pkg::S_EXEC:
            begin
                if (commit)
                begin
                    state_next = pfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pfa_pkg::S_CLEAR;
            end
        endcase
    end

    // Result of the command held in the sequencer, from the count just read.
    always_comb
    begin
        res.result_page = idx_reg;
        res.status      = pfa_pkg::ST_OK;
        res.count_after = pfa_pkg::COUNT_OUT_W'(cur_count);
        new_count       = cur_count;
        do_push         = 1'b0;
        cnt_write_op    = 1'b0;
        unique case (kind_reg)
            pfa_pkg::K_NOMEM:
            begin
                res.result_page = '0;
                res.status      = pfa_pkg::ST_NOMEM;
                res.count_after = '0;
            end
            pfa_pkg::K_RANGE:
            begin
                res.status      = pfa_pkg::ST_RESV;
                res.count_after = '0;
            end
            pfa_pkg::K_FRESH, pfa_pkg::K_POP:
            begin
                res.result_page = pfa_pkg::PAGE_W'(page_reg);
            end
            pfa_pkg::K_OP:
            begin
                if (op_idx_w < resv_lim)
                begin
                    res.status = pfa_pkg::ST_RESV;
                end
                else if (cnt_rdata[CW] || op_idx_w < LW'(fresh_reg))
                begin
                    res.status = pfa_pkg::ST_FREE;
                end
                else
                begin
                    cnt_write_op = 1'b1;
                    unique case (cmd_reg)
                        pfa_pkg::CMD_INC:
                        begin
                            if (cur_count == COUNT_MAX)
                            begin
                                res.status = pfa_pkg::ST_OVER;
                            end
                            else
                            begin
                                new_count = cur_count + CW'(1);
                            end
                        end
                        pfa_pkg::CMD_DEC:
                        begin
                            if (cur_count == '0)
                            begin
                                res.status = pfa_pkg::ST_UNDER;
                            end
                            else
                            begin
                                new_count = cur_count - CW'(1);
                                do_push   = (new_count == '0);
                            end
                        end
                        pfa_pkg::CMD_TRY:
                        begin
                            if (cur_count != '0)
                            begin
                                res.status = pfa_pkg::ST_REFD;
                            end
                            else
                            begin
                                do_push = 1'b1;
                            end
                        end
                        default:
                        begin
                            cnt_write_op = 1'b0;
                        end
                    endcase
                    res.count_after = pfa_pkg::COUNT_OUT_W'(new_count);
                end
            end
            default:
            begin
                res.status = pfa_pkg::ST_NOMEM;
            end
        endcase
    end

    assign push_ok = do_push && (fill_reg < NW'(PAGE_COUNT));

    // Memory ports and register updates.
    always_comb
    begin
        mem_en         = '0;
        cnt_waddr      = page_reg;
        cnt_wdata      = {push_ok, new_count};
        cnt_raddr      = PW'(in_data.page_index);
        stk_waddr      = PW'(fill_reg);
        stk_wdata      = page_reg;
        stk_raddr      = PW'(fill_reg - NW'(1));
        kind_next      = kind_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        page_next      = page_reg;
        clr_next       = clr_reg;
        fill_next      = fill_reg;
        fresh_next     = fresh_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            pfa_pkg::S_CLEAR:
            begin
                mem_en.cnt_we = 1'b1;
                cnt_waddr     = clr_reg;
                cnt_wdata     = '0;
                clr_next      = clr_reg + PW'(1);
            end
            pfa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = in_data.command;
                    idx_next  = in_data.page_index;
                    page_next = PW'(in_data.page_index);
                    if (in_data.command == pfa_pkg::CMD_ALLOC)
                    begin
                        if (fill_reg != '0)
                        begin
                            kind_next     = pfa_pkg::K_POP;
                            mem_en.stk_re = 1'b1;
                        end
                        else if (LW'(fresh_reg) > resv_lim)
                        begin
                            kind_next     = pfa_pkg::K_FRESH;
                            page_next     = PW'(fresh_reg - NW'(1));
                            cnt_raddr     = PW'(fresh_reg - NW'(1));
                            mem_en.cnt_re = 1'b1;
                        end
                        else
                        begin
                            kind_next = pfa_pkg::K_NOMEM;
                        end
                    end
                    else if (in_idx_w < LW'(PAGE_COUNT))
                    begin
                        kind_next     = pfa_pkg::K_OP;
                        mem_en.cnt_re = 1'b1;
                    end
                    else
                    begin
                        kind_next = pfa_pkg::K_RANGE;
                    end
                end
            end
            pfa_pkg::S_POP:
            begin
                page_next     = stk_rdata;
                cnt_raddr     = stk_rdata;
                mem_en.cnt_re = 1'b1;
            end
            pfa_pkg::S_EXEC:
            begin
                if (commit)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res;
                    if (kind_reg == pfa_pkg::K_POP)
                    begin
                        fill_next     = fill_reg - NW'(1);
                        mem_en.cnt_we = 1'b1;
                        cnt_wdata     = {1'b0, cur_count};
                    end
                    else if (kind_reg == pfa_pkg::K_FRESH)
                    begin
                        fresh_next = fresh_reg - NW'(1);
                    end
                    else if (cnt_write_op)
                    begin
                        mem_en.cnt_we = 1'b1;
                        if (push_ok)
                        begin
                            mem_en.stk_we = 1'b1;
                            fill_next     = fill_reg + NW'(1);
                        end
                    end
                end
            end
            default:
            begin
                mem_en = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfa_pkg::S_CLEAR;
            clr_reg       <= '0;
            fill_reg      <= '0;
            fresh_reg     <= NW'(PAGE_COUNT);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            fill_reg      <= fill_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        page_reg     <= page_next;
        out_data_reg <= out_data_next;
    end

    `PFA_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= NW'(PAGE_COUNT), "free stack fill exceeds page count")
    `PFA_ASSERT_SAME(a_stack_push_room, mem_en.stk_we, fill_reg < NW'(PAGE_COUNT), "push onto a full free stack")
    `PFA_ASSERT_SAME(a_count_write_phase, mem_en.cnt_we, (state_reg == pfa_pkg::S_CLEAR) || commit, "count memory written outside clear or commit")
    `PFA_ASSERT_NEXT(a_fresh_step, commit && (kind_reg == pfa_pkg::K_FRESH), fresh_reg == $past(fresh_reg) - NW'(1), "fresh limit did not step down on allocation")
    `PFA_ASSERT_NEXT(a_accept_to_work, accept, (state_reg == pfa_pkg::S_POP) || (state_reg == pfa_pkg::S_EXEC), "accepted request not taken up")

endmodule

>>> sv/page_frame_allocator_refcount.sv
// Top level of the page frame allocator with reference counts: configuration register,
// count memory, free stack memory and the command sequencer. Depends on pfa_pkg, pfa_ram, pfa_ctrl.
`timescale 1ns / 1ps

// The count memory is read in the accept cycle; the updated entry is written back and the
// result loaded at commit, which waits while the output is stalled. An allocate that
// pops the free stack passes through the pop state, because the stack read must finish
// before the count of the popped page can be read. Both memories have a registered read,
// and only one request is in flight at a time. After reset the block clears all
// PAGE_COUNT entries (4096 by default) of the count memory one entry per cycle, with
// in_stall high; the reserved page register can be written at any time the block is idle.
module page_frame_allocator_refcount #(
    parameter int PAGE_COUNT  = pfa_pkg::PAGE_COUNT_DEF,
    parameter int COUNT_WIDTH = pfa_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pfa_pkg::RESV_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  pfa_pkg::in_req_t           in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output pfa_pkg::out_req_t          out_data
);

    localparam int PW = $clog2(PAGE_COUNT);

    logic [pfa_pkg::RESV_W-1:0] reserved_reg;
    logic [pfa_pkg::RESV_W-1:0] reserved_next;
    pfa_pkg::mem_en_t           mem_en;
    logic [PW-1:0]              cnt_waddr;
    logic [COUNT_WIDTH:0]       cnt_wdata;
    logic [PW-1:0]              cnt_raddr;
    logic [COUNT_WIDTH:0]       cnt_rdata;
    logic [PW-1:0]              stk_waddr;
    logic [PW-1:0]              stk_wdata;
    logic [PW-1:0]              stk_raddr;
    logic [PW-1:0]              stk_rdata;

    assign cfg_ready     = 1'b1;
    assign reserved_next = (cfg_valid && cfg_ready) ? cfg_data : reserved_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= '0;
        end
        else
        begin
            reserved_reg <= reserved_next;
        end
    end

    pfa_ram #(
        .WIDTH (COUNT_WIDTH + 1),
        .DEPTH (PAGE_COUNT)
    ) u_count_ram (
        .clk   (clk),
        .we    (mem_en.cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (mem_en.cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    pfa_ram #(
        .WIDTH (PW),
        .DEPTH (PAGE_COUNT)
    ) u_stack_ram (
        .clk   (clk),
        .we    (mem_en.stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (mem_en.stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    pfa_ctrl #(
        .PAGE_COUNT  (PAGE_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .reserved_pages (reserved_reg),
        .mem_en         (mem_en),
        .cnt_waddr      (cnt_waddr),
        .cnt_wdata      (cnt_wdata),
        .cnt_raddr      (cnt_raddr),
        .cnt_rdata      (cnt_rdata),
        .stk_waddr      (stk_waddr),
        .stk_wdata      (stk_wdata),
        .stk_raddr      (stk_raddr),
        .stk_rdata      (stk_rdata)
    );

endmodule

>>> test/page_frame_allocator_refcount_tb.sv
// Self-checking testbench for page_frame_allocator_refcount: a scoreboard class predicts
// every response from its own model of the frame store; tasks drive requests and config.
// Depends on pfa_pkg and the page_frame_allocator_refcount RTL.
`timescale 1ns / 1ps

module page_frame_allocator_refcount_tb;

    localparam int PAGES = pfa_pkg::PAGE_COUNT_DEF;
    localparam int CMAX = (1 << pfa_pkg::COUNT_WIDTH_DEF) - 1;
    localparam int STALL_LIMIT = 20000;
    localparam int PW = pfa_pkg::PAGE_W;
    localparam int CW = pfa_pkg::COUNT_OUT_W;
    localparam int RW = pfa_pkg::RESV_W;

    class frame_scoreboard;
        bit [CW-1:0] ref_count [PAGES];
        bit [PW-1:0] freed_stack [PAGES];
        bit on_stack [PAGES];
        int unsigned stack_fill;
        int unsigned fresh_limit;
        int unsigned reserved;
        int unsigned held_q [$];
        pfa_pkg::out_req_t expected_q [$];
        int errors;

        function new();
            stack_fill = 0;
            fresh_limit = PAGES;
            reserved = 0;
            errors = 0;
        endfunction

        function int unsigned resv_limit();
            return (reserved > PAGES) ? PAGES : reserved;
        endfunction

        function void release_page(int unsigned p);
            int hits [$];
            if (stack_fill < PAGES)
            begin
                freed_stack[stack_fill] = PW'(p);
                stack_fill++;
                on_stack[p] = 1'b1;
            end
            hits = held_q.find_first_index(x) with (x == p);
            if (hits.size() > 0)
                held_q.delete(hits[0]);
        endfunction

        function void note_request(pfa_pkg::in_req_t r);
            pfa_pkg::out_req_t e;
            int unsigned p;
            int unsigned c;
            int unsigned lim;
            p = 32'(r.page_index);
            lim = resv_limit();
            e.result_page = r.page_index;
            e.status = pfa_pkg::ST_OK;
            e.count_after = '0;
            if (r.command == pfa_pkg::CMD_ALLOC)
            begin
                if (stack_fill > 0)
                begin
                    stack_fill--;
                    p = 32'(freed_stack[stack_fill]);
                    on_stack[p] = 1'b0;
                    e.result_page = PW'(p);
                    e.count_after = ref_count[p];
                    held_q.push_back(p);
                end
                else if (fresh_limit > lim)
                begin
                    fresh_limit--;
                    p = fresh_limit;
                    e.result_page = PW'(p);
                    e.count_after = ref_count[p];
                    held_q.push_back(p);
                end
                else
                begin
                    e.result_page = '0;
                    e.status = pfa_pkg::ST_NOMEM;
                end
            end
            else if (p < lim)
            begin
                e.status = pfa_pkg::ST_RESV;
                e.count_after = ref_count[p];
            end
            else if (on_stack[p] || p < fresh_limit)
            begin
                e.status = pfa_pkg::ST_FREE;
                e.count_after = ref_count[p];
            end
            else
            begin
                c = 32'(ref_count[p]);
                case (r.command)
                    pfa_pkg::CMD_INC:
                    begin
                        if (c >= CMAX)
                            e.status = pfa_pkg::ST_OVER;
                        else
                            c++;
                    end
                    pfa_pkg::CMD_DEC:
                    begin
                        if (c == 0)
                        begin
                            e.status = pfa_pkg::ST_UNDER;
                        end
                        else
                        begin
                            c--;
                            if (c == 0)
                                release_page(p);
                        end
                    end
                    default:
                    begin
                        if (c != 0)
                            e.status = pfa_pkg::ST_REFD;
                        else
                            release_page(p);
                    end
                endcase
                ref_count[p] = CW'(c);
                e.count_after = CW'(c);
            end
            expected_q.push_back(e);
        endfunction

        function void mismatch(string field, int unsigned want, int unsigned got);
            errors++;
            if (errors <= 50)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_result(pfa_pkg::out_req_t got);
            pfa_pkg::out_req_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 50)
                    $display("%0t: unexpected response, expected none, actual %p", $time, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.result_page !== want.result_page)
                mismatch("result_page", 32'(want.result_page), 32'(got.result_page));
            if (got.status !== want.status)
                mismatch("status", 32'(want.status), 32'(got.status));
            if (got.count_after !== want.count_after)
                mismatch("count_after", 32'(want.count_after), 32'(got.count_after));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [RW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    pfa_pkg::in_req_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    pfa_pkg::out_req_t out_data;

    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    int unsigned quiet_cycles = 0;
    frame_scoreboard book;

    page_frame_allocator_refcount dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            book.check_result(out_data);
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                snd_idle_pct = 18;
                rcv_idle_pct = 55;
            end
            1:
            begin
                snd_idle_pct = 55;
                rcv_idle_pct = 18;
            end
            default:
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic send_request(input pfa_pkg::cmd_t c, input logic [PW-1:0] p);
        pfa_pkg::in_req_t r;
        r.command = c;
        r.page_index = p;
        if ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < snd_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        book.note_request(r);
    endtask

    task automatic wait_drained();
        while (book.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reserved(input int unsigned value);
        in_valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= RW'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        book.reserved = value;
    endtask

    task automatic random_request();
        int unsigned roll;
        int unsigned n;
        pfa_pkg::cmd_t c;
        logic [PW-1:0] p;
        roll = $urandom_range(99);
        n = book.held_q.size();
        p = PW'($urandom);
        if (roll < 30)
        begin
            c = pfa_pkg::CMD_ALLOC;
        end
        else if (roll < 93 && n > 0)
        begin
            p = PW'(book.held_q[$urandom_range(n - 1)]);
            if (roll < 55)
                c = pfa_pkg::CMD_INC;
            else if (roll < 85)
                c = pfa_pkg::CMD_DEC;
            else
                c = pfa_pkg::CMD_TRY;
        end
        else
        begin
            c = pfa_pkg::cmd_t'($urandom_range(3));
        end
        send_request(c, p);
    endtask

    initial
    begin
        int unsigned phase_resv [6];
        int unsigned phase_items [6];
        int unsigned p;
        book = new();
        phase_resv = '{4088, 0, $urandom_range(2, 4087), 4096, 4032, 1};
        phase_items = '{160, 160, 160, 60, 180, 180};
        set_idling(0);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_reserved(4093);
        send_request(pfa_pkg::CMD_ALLOC, 12'h000);
        send_request(pfa_pkg::CMD_INC, 12'hfff);
        send_request(pfa_pkg::CMD_INC, 12'hfff);
        send_request(pfa_pkg::CMD_DEC, 12'hfff);
        send_request(pfa_pkg::CMD_TRY, 12'hfff);
        send_request(pfa_pkg::CMD_DEC, 12'hfff);
        send_request(pfa_pkg::CMD_DEC, 12'hfff);
        send_request(pfa_pkg::CMD_TRY, 12'hfff);
        send_request(pfa_pkg::CMD_INC, 12'hffe);
        send_request(pfa_pkg::CMD_INC, 12'h000);
        send_request(pfa_pkg::CMD_ALLOC, 12'hfff);
        send_request(pfa_pkg::CMD_ALLOC, 12'h000);
        send_request(pfa_pkg::CMD_ALLOC, 12'h555);
        send_request(pfa_pkg::CMD_ALLOC, 12'haaa);
        send_request(pfa_pkg::CMD_DEC, 12'hffd);
        send_request(pfa_pkg::CMD_TRY, 12'hffd);
        send_request(pfa_pkg::CMD_TRY, 12'hffe);
        send_request(pfa_pkg::CMD_ALLOC, 12'h000);
        write_reserved(8191);
        send_request(pfa_pkg::CMD_ALLOC, 12'h000);
        send_request(pfa_pkg::CMD_ALLOC, 12'h000);
        send_request(pfa_pkg::CMD_INC, 12'hfff);

        for (int ph = 0; ph < 6; ph++)
        begin
            set_idling(ph / 2);
            write_reserved(phase_resv[ph]);
            for (int i = 0; i < phase_items[ph]; i++)
                random_request();
        end

        send_request(pfa_pkg::CMD_ALLOC, 12'h000);
        if (book.held_q.size() > 0)
        begin
            p = book.held_q[book.held_q.size() - 1];
            send_request(pfa_pkg::CMD_INC, PW'(p));
            send_request(pfa_pkg::CMD_TRY, PW'(p));
            send_request(pfa_pkg::CMD_DEC, PW'(p));
            send_request(pfa_pkg::CMD_TRY, PW'(p));
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        if (book.errors == 0 && book.expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
